// File: rtl/dbba_pkg.sv
// Shared types and constants for the disk block bitmap allocator.
`default_nettype none

package dbba_pkg;

    localparam int unsigned MAX_RESULTS = 64;

    localparam int unsigned COUNT_W  = 7;
    localparam int unsigned STATUS_W = 3;

    localparam logic [STATUS_W-1:0] ST_ALLOCATED = 3'd0;
    localparam logic [STATUS_W-1:0] ST_RELEASED  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NO_SPACE  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_ADDR  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOT_TAKEN = 3'd4;

    localparam logic ACT_ALLOCATE = 1'b0;
    localparam logic ACT_RELEASE  = 1'b1;

    // Control of the scan address counter.
    typedef struct packed {
        logic restart;
        logic step;
    } scan_ctl_t;

endpackage

`default_nettype wire

// File: rtl/dbba_bitmap_ram.sv
// Synchronous one-bit-per-block bitmap memory with registered read data.
`default_nettype none

module dbba_bitmap_ram #(
    parameter int unsigned DEPTH = 64,
    parameter int unsigned AW    = 6
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic          wdata,
    input  wire logic          re,
    input  wire logic [AW-1:0] raddr,
    output logic               rdata
);

    logic mem [DEPTH];
    logic rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: rtl/dbba_scan_counter.sv
// Scan address counter: linear block index with cylinder, track and record digits.
`default_nettype none

module dbba_scan_counter #(
    parameter int unsigned CYLINDERS = 8,
    parameter int unsigned TRACKS    = 2,
    parameter int unsigned RECORDS   = 4,
    parameter int unsigned IDX_W     = 6,
    parameter int unsigned CYL_W     = 3,
    parameter int unsigned TRK_W     = 1,
    parameter int unsigned REC_W     = 2
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire dbba_pkg::scan_ctl_t ctl,
    output logic [IDX_W-1:0]        idx,
    output logic [CYL_W-1:0]        cyl,
    output logic [TRK_W-1:0]        trk,
    output logic [REC_W-1:0]        rec
);

    localparam int unsigned TOTAL = CYLINDERS * TRACKS * RECORDS;

    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [CYL_W-1:0] cyl_reg, cyl_next;
    logic [TRK_W-1:0] trk_reg, trk_next;
    logic [REC_W-1:0] rec_reg, rec_next;

    always_comb
    begin
        idx_next = idx_reg;
        cyl_next = cyl_reg;
        trk_next = trk_reg;
        rec_next = rec_reg;
        if (ctl.restart)
        begin
            idx_next = '0;
            cyl_next = '0;
            trk_next = '0;
            rec_next = '0;
        end
        else if (ctl.step)
        begin
            // The counter wraps after the last block; a read issued past the
            // end is never used because a scan always finds enough free blocks.
            if (idx_reg == IDX_W'(TOTAL - 1))
            begin
                idx_next = '0;
            end
            else
            begin
                idx_next = idx_reg + IDX_W'(1);
            end
            if (rec_reg == REC_W'(RECORDS - 1))
            begin
                rec_next = '0;
                if (trk_reg == TRK_W'(TRACKS - 1))
                begin
                    trk_next = '0;
                    if (cyl_reg == CYL_W'(CYLINDERS - 1))
                    begin
                        cyl_next = '0;
                    end
                    else
                    begin
                        cyl_next = cyl_reg + CYL_W'(1);
                    end
                end
                else
                begin
                    trk_next = trk_reg + TRK_W'(1);
                end
            end
            else
            begin
                rec_next = rec_reg + REC_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
            cyl_reg <= '0;
            trk_reg <= '0;
            rec_reg <= '0;
        end
        else
        begin
            idx_reg <= idx_next;
            cyl_reg <= cyl_next;
            trk_reg <= trk_next;
            rec_reg <= rec_next;
        end
    end

    assign idx = idx_reg;
    assign cyl = cyl_reg;
    assign trk = trk_reg;
    assign rec = rec_reg;

endmodule

`default_nettype wire

// File: rtl/disk_block_bitmap_allocator_unit.sv
// Top level of the disk block bitmap allocator: control, free count and output register.
//
// Input channel (in_valid/in_ready) carries allocate or release items; the
// output channel (out_valid/out_ready) carries one result item per allocated
// block, or a single status item, with last set on the final one.
// After reset a clearing pass writes every bitmap entry free, one entry per
// cycle; in_ready stays low during it.
// An allocate item of n blocks scans the bitmap memory one entry per cycle
// from block 0 while the output register can take results, up to and
// including the n-th free block; the read of the next entry overlaps the check
// of the current one. Each free block found is marked taken and its address goes
// to the output register. An allocate item for zero blocks produces no result.
// A release item reads its entry, then checks it and writes it back free if taken.
// Insufficient-space and bad-address items go through a response state.
// The block works on one item at a time; in_ready is high only while idle.
// A pending result in the output register does not block acceptance; when
// the receiver stalls, the scan holds its place until the register frees.
`default_nettype none

module disk_block_bitmap_allocator_unit #(
    parameter int unsigned CYLINDERS = 8,
    parameter int unsigned TRACKS    = 2,
    parameter int unsigned RECORDS   = 4
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic       action,
    input  wire logic [6:0] block_count,
    input  wire logic [3:0] cylinder_number,
    input  wire logic [1:0] track_number,
    input  wire logic [2:0] record_number,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [2:0]      status,
    output logic [2:0]      out_cylinder,
    output logic            out_track,
    output logic [1:0]      out_record,
    output logic            last
);

    localparam int unsigned TR     = TRACKS * RECORDS;
    localparam int unsigned TOTAL  = CYLINDERS * TR;
    localparam int unsigned IDX_W  = (TOTAL > 1) ? $clog2(TOTAL) : 1;
    localparam int unsigned FREE_W = $clog2(TOTAL + 1);
    localparam int unsigned CYL_W  = (CYLINDERS > 1) ? $clog2(CYLINDERS) : 1;
    localparam int unsigned TRK_W  = (TRACKS > 1) ? $clog2(TRACKS) : 1;
    localparam int unsigned REC_W  = (RECORDS > 1) ? $clog2(RECORDS) : 1;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_REL_CHK,
        S_RESP
    } state_t;

    state_t state_reg, state_next;

    logic [IDX_W-1:0]              clr_idx_reg, clr_idx_next;
    logic [FREE_W-1:0]             free_reg, free_next;
    logic [dbba_pkg::COUNT_W-1:0]  want_reg, want_next;
    logic [dbba_pkg::COUNT_W-1:0]  got_reg, got_next;
    logic                          data_vld_reg, data_vld_next;
    logic [IDX_W-1:0]              chk_idx_reg, chk_idx_next;
    logic [CYL_W-1:0]              chk_cyl_reg, chk_cyl_next;
    logic [TRK_W-1:0]              chk_trk_reg, chk_trk_next;
    logic [REC_W-1:0]              chk_rec_reg, chk_rec_next;
    logic [IDX_W-1:0]              rel_idx_reg, rel_idx_next;
    logic [dbba_pkg::STATUS_W-1:0] resp_reg, resp_next;

    logic                          out_valid_reg, out_valid_next;
    logic [dbba_pkg::STATUS_W-1:0] status_reg, status_next;
    logic [2:0]                    out_cyl_reg, out_cyl_next;
    logic                          out_trk_reg, out_trk_next;
    logic [1:0]                    out_rec_reg, out_rec_next;
    logic                          last_reg, last_next;

    logic             ram_we, ram_wdata, ram_re, ram_rdata;
    logic [IDX_W-1:0] ram_waddr, ram_raddr;

    dbba_pkg::scan_ctl_t scan_ctl;
    logic [IDX_W-1:0]    scan_idx;
    logic [CYL_W-1:0]    scan_cyl;
    logic [TRK_W-1:0]    scan_trk;
    logic [REC_W-1:0]    scan_rec;

    logic             out_free;
    logic             out_load;
    logic             stall;
    logic             alloc_last;
    logic             bad_addr;
    logic [IDX_W-1:0] rel_idx;
    logic [7:0]       cyl_wide;
    logic [7:0]       trk_wide;
    logic [7:0]       rec_wide;

    dbba_bitmap_ram #(
        .DEPTH (TOTAL),
        .AW    (IDX_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    dbba_scan_counter #(
        .CYLINDERS (CYLINDERS),
        .TRACKS    (TRACKS),
        .RECORDS   (RECORDS),
        .IDX_W     (IDX_W),
        .CYL_W     (CYL_W),
        .TRK_W     (TRK_W),
        .REC_W     (REC_W)
    ) u_scan (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (scan_ctl),
        .idx   (scan_idx),
        .cyl   (scan_cyl),
        .trk   (scan_trk),
        .rec   (scan_rec)
    );

    assign in_ready = (state_reg == S_IDLE);
    assign out_free = !out_valid_reg || out_ready;

    assign bad_addr = (32'(cylinder_number) >= CYLINDERS) ||
                      (32'(track_number) >= TRACKS) ||
                      (32'(record_number) >= RECORDS);
    assign rel_idx  = IDX_W'(32'(cylinder_number) * TR +
                             32'(track_number) * RECORDS +
                             32'(record_number));

    // Allocated addresses are reported in the fixed output widths.
    assign cyl_wide = 8'(chk_cyl_reg);
    assign trk_wide = 8'(chk_trk_reg);
    assign rec_wide = 8'(chk_rec_reg);

    // The checked entry is free but the output register cannot take it yet.
    assign stall      = data_vld_reg && !ram_rdata && !out_free;
    assign alloc_last = (dbba_pkg::COUNT_W'(got_reg + 1'b1) == want_reg);

    always_comb
    begin
        state_next     = state_reg;
        clr_idx_next   = clr_idx_reg;
        free_next      = free_reg;
        want_next      = want_reg;
        got_next       = got_reg;
        data_vld_next  = data_vld_reg;
        chk_idx_next   = chk_idx_reg;
        chk_cyl_next   = chk_cyl_reg;
        chk_trk_next   = chk_trk_reg;
        chk_rec_next   = chk_rec_reg;
        rel_idx_next   = rel_idx_reg;
        resp_next      = resp_reg;
        status_next    = status_reg;
        out_cyl_next   = out_cyl_reg;
        out_trk_next   = out_trk_reg;
        out_rec_next   = out_rec_reg;
        last_next      = last_reg;
        out_load       = 1'b0;
        ram_we         = 1'b0;
        ram_waddr      = clr_idx_reg;
        ram_wdata      = 1'b0;
        ram_re         = 1'b0;
        ram_raddr      = scan_idx;
        scan_ctl       = '0;

        unique case (state_reg)
            S_CLEAR:
            begin
                ram_we       = 1'b1;
                clr_idx_next = clr_idx_reg + IDX_W'(1);
                if (clr_idx_reg == IDX_W'(TOTAL - 1))
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (action == dbba_pkg::ACT_ALLOCATE)
                    begin
                        if (block_count == '0)
                        begin
                            state_next = S_IDLE;
                        end
                        else if ((32'(block_count) > dbba_pkg::MAX_RESULTS) ||
                                 (32'(block_count) > 32'(free_reg)))
                        begin
                            resp_next  = dbba_pkg::ST_NO_SPACE;
                            state_next = S_RESP;
                        end
                        else
                        begin
                            want_next        = block_count;
                            got_next         = '0;
                            data_vld_next    = 1'b0;
                            scan_ctl.restart = 1'b1;
                            state_next       = S_SCAN;
                        end
                    end
                    else
                    begin
                        if (bad_addr)
                        begin
                            resp_next  = dbba_pkg::ST_BAD_ADDR;
                            state_next = S_RESP;
                        end
                        else
                        begin
                            ram_re       = 1'b1;
                            ram_raddr    = rel_idx;
                            rel_idx_next = rel_idx;
                            state_next   = S_REL_CHK;
                        end
                    end
                end
            end

            S_SCAN:
            begin
                if (!stall)
                begin
                    if (data_vld_reg && !ram_rdata)
                    begin
                        ram_we       = 1'b1;
                        ram_waddr    = chk_idx_reg;
                        ram_wdata    = 1'b1;
                        out_load     = 1'b1;
                        status_next  = dbba_pkg::ST_ALLOCATED;
                        out_cyl_next = cyl_wide[2:0];
                        out_trk_next = trk_wide[0];
                        out_rec_next = rec_wide[1:0];
                        last_next    = alloc_last;
                        got_next     = dbba_pkg::COUNT_W'(got_reg + 1'b1);
                    end
                    if (data_vld_reg && !ram_rdata && alloc_last)
                    begin
                        free_next     = free_reg - FREE_W'(want_reg);
                        data_vld_next = 1'b0;
                        state_next    = S_IDLE;
                    end
                    else
                    begin
                        // Read the next entry while the current one is checked.
                        ram_re        = 1'b1;
                        ram_raddr     = scan_idx;
                        scan_ctl.step = 1'b1;
                        chk_idx_next  = scan_idx;
                        chk_cyl_next  = scan_cyl;
                        chk_trk_next  = scan_trk;
                        chk_rec_next  = scan_rec;
                        data_vld_next = 1'b1;
                    end
                end
            end

            S_REL_CHK:
            begin
                if (out_free)
                begin
                    out_load     = 1'b1;
                    out_cyl_next = '0;
                    out_trk_next = 1'b0;
                    out_rec_next = '0;
                    last_next    = 1'b1;
                    if (ram_rdata)
                    begin
                        ram_we      = 1'b1;
                        ram_waddr   = rel_idx_reg;
                        ram_wdata   = 1'b0;
                        free_next   = free_reg + FREE_W'(1);
                        status_next = dbba_pkg::ST_RELEASED;
                    end
                    else
                    begin
                        status_next = dbba_pkg::ST_NOT_TAKEN;
                    end
                    state_next = S_IDLE;
                end
            end

            S_RESP:
            begin
                if (out_free)
                begin
                    out_load     = 1'b1;
                    status_next  = resp_reg;
                    out_cyl_next = '0;
                    out_trk_next = 1'b0;
                    out_rec_next = '0;
                    last_next    = 1'b1;
                    state_next   = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        out_valid_next = out_load || (out_valid_reg && !out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_idx_reg   <= '0;
            free_reg      <= FREE_W'(TOTAL);
            want_reg      <= '0;
            got_reg       <= '0;
            data_vld_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_idx_reg   <= clr_idx_next;
            free_reg      <= free_next;
            want_reg      <= want_next;
            got_reg       <= got_next;
            data_vld_reg  <= data_vld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        chk_idx_reg <= chk_idx_next;
        chk_cyl_reg <= chk_cyl_next;
        chk_trk_reg <= chk_trk_next;
        chk_rec_reg <= chk_rec_next;
        rel_idx_reg <= rel_idx_next;
        resp_reg    <= resp_next;
        status_reg  <= status_next;
        out_cyl_reg <= out_cyl_next;
        out_trk_reg <= out_trk_next;
        out_rec_reg <= out_rec_next;
        last_reg    <= last_next;
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign out_cylinder = out_cyl_reg;
    assign out_track    = out_trk_reg;
    assign out_record   = out_rec_reg;
    assign last         = last_reg;

    // The free count can never exceed the number of blocks on the disk.
    a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
        free_reg <= FREE_W'(TOTAL))
    else $error("free block count exceeds disk size");

    // A scan is never still running once the requested count has been met.
    a_scan_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (got_reg < want_reg))
    else $error("scan running after all blocks were allocated");

    // Loading a result flagged last always ends the item.
    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && last_next) |=> (state_reg == S_IDLE))
    else $error("last result loaded but item did not finish");

    // A stalled scan issues no bitmap write.
    a_stall_nowrite: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_SCAN) && stall) |-> !ram_we)
    else $error("bitmap written while scan stalled");

endmodule

`default_nettype wire

// File: tb/disk_block_bitmap_allocator_checker.sv
`timescale 1ns / 100ps
// Checker for the disk block bitmap allocator: tracks the bitmap and compares every result item.
module disk_block_bitmap_allocator_checker #(
    parameter int unsigned CYLINDERS = 8,
    parameter int unsigned TRACKS    = 2,
    parameter int unsigned RECORDS   = 4
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    in_valid,
    input  logic                                    in_ready,
    input  logic                                    action,
    input  logic [6:0]                              block_count,
    input  logic [3:0]                              cylinder_number,
    input  logic [1:0]                              track_number,
    input  logic [2:0]                              record_number,
    input  logic                                    out_valid,
    input  logic                                    out_ready,
    input  logic [2:0]                              status,
    input  logic [2:0]                              out_cylinder,
    input  logic                                    out_track,
    input  logic [1:0]                              out_record,
    input  logic                                    last,
    output int                                      error_count,
    output int                                      pending_results,
    output int                                      items_checked,
    output int                                      results_checked,
    output logic [CYLINDERS*TRACKS*RECORDS-1:0]     taken_map
);

    localparam int unsigned BLOCKS        = CYLINDERS * TRACKS * RECORDS;
    localparam int unsigned CYLINDER_SIZE = TRACKS * RECORDS;

    typedef struct packed {
        logic [2:0] status;
        logic [2:0] cylinder;
        logic       track;
        logic [1:0] record_no;
        logic       last;
    } block_result_t;

    block_result_t expected_results[$];
    block_result_t predicted;
    int unsigned   free_blocks;
    int unsigned   wanted;
    int unsigned   granted;
    int unsigned   slot;

    function automatic block_result_t single_status(logic [2:0] code);
        block_result_t r;
        r        = '0;
        r.status = code;
        r.last   = 1'b1;
        return r;
    endfunction

    function automatic void check_field(string field, int unsigned want_v, int unsigned got_v);
        if (want_v != got_v) begin
            error_count++;
            $error("%s: expected %0d, got %0d", field, want_v, got_v);
        end
    endfunction

    initial begin
        error_count     = 0;
        items_checked   = 0;
        results_checked = 0;
        pending_results = 0;
        free_blocks     = BLOCKS;
        taken_map       = '0;
    end

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            taken_map   = '0;
            free_blocks = BLOCKS;
            expected_results.delete();
            pending_results = 0;
        end else begin
            // Results leave the output register before any item accepted at this edge
            // can produce one, so comparing first keeps the queue in order.
            if (out_valid && out_ready) begin
                results_checked++;
                if (expected_results.size() == 0) begin
                    error_count++;
                    $error("status: expected no result, got %0d", status);
                end else begin
                    predicted = expected_results.pop_front();
                    check_field("status", predicted.status, status);
                    check_field("out_cylinder", predicted.cylinder, out_cylinder);
                    check_field("out_track", predicted.track, out_track);
                    check_field("out_record", predicted.record_no, out_record);
                    check_field("last", predicted.last, last);
                end
            end

            if (in_valid && in_ready) begin
                items_checked++;
                if (action == dbba_pkg::ACT_ALLOCATE) begin
                    wanted = block_count;
                    if (wanted == 0) begin
                        // A request for nothing produces no result at all.
                    end else if (wanted > dbba_pkg::MAX_RESULTS || wanted > free_blocks) begin
                        expected_results.push_back(single_status(dbba_pkg::ST_NO_SPACE));
                    end else begin
                        granted = 0;
                        for (int idx = 0; idx < BLOCKS && granted < wanted; idx++) begin
                            if (!taken_map[idx]) begin
                                taken_map[idx]      = 1'b1;
                                granted++;
                                predicted           = '0;
                                predicted.status    = dbba_pkg::ST_ALLOCATED;
                                predicted.cylinder  = 3'(idx / CYLINDER_SIZE);
                                predicted.track     = 1'((idx % CYLINDER_SIZE) / RECORDS);
                                predicted.record_no = 2'(idx % RECORDS);
                                predicted.last      = (granted == wanted);
                                expected_results.push_back(predicted);
                            end
                        end
                        free_blocks -= granted;
                    end
                end else if (cylinder_number >= CYLINDERS || track_number >= TRACKS
                             || record_number >= RECORDS) begin
                    expected_results.push_back(single_status(dbba_pkg::ST_BAD_ADDR));
                end else begin
                    slot = cylinder_number * CYLINDER_SIZE + track_number * RECORDS
                           + record_number;
                    if (!taken_map[slot]) begin
                        expected_results.push_back(single_status(dbba_pkg::ST_NOT_TAKEN));
                    end else begin
                        taken_map[slot] = 1'b0;
                        free_blocks++;
                        expected_results.push_back(single_status(dbba_pkg::ST_RELEASED));
                    end
                end
            end

            pending_results = expected_results.size();
        end
    end

endmodule

// File: tb/disk_block_bitmap_allocator_unit_test.sv
`timescale 1ns / 100ps
// Testbench top for the disk block bitmap allocator: stimulus, handshake pacing and verdict.
module disk_block_bitmap_allocator_unit_test;

    localparam int unsigned CYLINDERS         = 8;
    localparam int unsigned TRACKS            = 2;
    localparam int unsigned RECORDS           = 4;
    localparam int unsigned BLOCKS            = CYLINDERS * TRACKS * RECORDS;
    localparam int unsigned LONG_STALL_CYCLES = 200;
    localparam int unsigned DRAIN_CYCLES      = 2 * BLOCKS + 16;
    localparam int unsigned ITEMS_PER_PHASE   = 27;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    logic              action;
    logic [6:0]        block_count;
    logic [3:0]        cylinder_number;
    logic [1:0]        track_number;
    logic [2:0]        record_number;
    logic              out_valid;
    logic              out_ready;
    logic [2:0]        status;
    logic [2:0]        out_cylinder;
    logic              out_track;
    logic [1:0]        out_record;
    logic              last;

    int                error_count;
    int                pending_results;
    int                items_checked;
    int                results_checked;
    logic [BLOCKS-1:0] taken_map;

    int                sender_idle_pct;
    int                receiver_stall_pct;
    int                stall_requests;
    int                stalls_served;

    int                phase_idle[4]  = '{0, 67, 0, 22};
    int                phase_stall[4] = '{0, 0, 67, 22};

    disk_block_bitmap_allocator_unit #(
        .CYLINDERS(CYLINDERS),
        .TRACKS   (TRACKS),
        .RECORDS  (RECORDS)
    ) DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .action         (action),
        .block_count    (block_count),
        .cylinder_number(cylinder_number),
        .track_number   (track_number),
        .record_number  (record_number),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .status         (status),
        .out_cylinder   (out_cylinder),
        .out_track      (out_track),
        .out_record     (out_record),
        .last           (last)
    );

    disk_block_bitmap_allocator_checker #(
        .CYLINDERS(CYLINDERS),
        .TRACKS   (TRACKS),
        .RECORDS  (RECORDS)
    ) result_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .action         (action),
        .block_count    (block_count),
        .cylinder_number(cylinder_number),
        .track_number   (track_number),
        .record_number  (record_number),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .status         (status),
        .out_cylinder   (out_cylinder),
        .out_track      (out_track),
        .out_record     (out_record),
        .last           (last),
        .error_count    (error_count),
        .pending_results(pending_results),
        .items_checked  (items_checked),
        .results_checked(results_checked),
        .taken_map      (taken_map)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial begin
        #1_500_000;
        $display("DONE: errors detected");
        $finish;
    end

    // Result side: random stalls, plus an occasional long hold-off on request.
    initial begin
        out_ready = 1'b0;
        forever begin
            @(negedge clk);
            if (stall_requests != stalls_served) begin
                out_ready <= 1'b0;
                repeat (LONG_STALL_CYCLES) @(negedge clk);
                stalls_served++;
            end
            out_ready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    task automatic send_item(input logic act, input logic [6:0] count, input logic [3:0] cyl,
                             input logic [1:0] trk, input logic [2:0] rec);
        while ($urandom_range(99) < sender_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        action          <= act;
        block_count     <= count;
        cylinder_number <= cyl;
        track_number    <= trk;
        record_number   <= rec;
        in_valid        <= 1'b1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
    endtask

    // Mostly allocations of a few blocks and releases of blocks known to be taken,
    // with oversized, empty, free-block and out-of-range items mixed in.
    task automatic send_random_item();
        int unsigned pick;
        int unsigned sel;
        int unsigned idx;
        logic [6:0]  count;
        pick = $urandom_range(99);
        if (pick < 50) begin
            sel = $urandom_range(99);
            if (sel < 62)
                count = 7'($urandom_range(1, 4));
            else if (sel < 82)
                count = 7'($urandom_range(5, 16));
            else if (sel < 87)
                count = 7'($urandom_range(17, 64));
            else if (sel < 93)
                count = 7'd0;
            else
                count = 7'($urandom_range(65, 127));
            send_item(dbba_pkg::ACT_ALLOCATE, count, 4'($urandom), 2'($urandom),
                      3'($urandom));
        end else if (pick < 92) begin
            if (pick < 85 && taken_map != '0) begin
                idx = $urandom_range(BLOCKS - 1);
                while (!taken_map[idx]) idx = (idx + 1) % BLOCKS;
            end else begin
                idx = $urandom_range(BLOCKS - 1);
            end
            send_item(dbba_pkg::ACT_RELEASE, 7'($urandom), 4'(idx / (TRACKS * RECORDS)),
                      2'((idx / RECORDS) % TRACKS), 3'(idx % RECORDS));
        end else begin
            sel = $urandom_range(2);
            send_item(dbba_pkg::ACT_RELEASE, 7'($urandom),
                      (sel == 0) ? 4'($urandom_range(CYLINDERS, 15)) : 4'($urandom),
                      (sel == 1) ? 2'($urandom_range(TRACKS, 3)) : 2'($urandom),
                      (sel == 2) ? 3'($urandom_range(RECORDS, 7)) : 3'($urandom));
        end
    endtask

    initial begin
        rst_n              = 1'b0;
        in_valid           = 1'b0;
        action             = dbba_pkg::ACT_ALLOCATE;
        block_count        = '0;
        cylinder_number    = '0;
        track_number       = '0;
        record_number      = '0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        stall_requests     = 0;
        stalls_served      = 0;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_item(dbba_pkg::ACT_ALLOCATE, 7'd0, 4'd15, 2'd3, 3'd7);
        send_item(dbba_pkg::ACT_ALLOCATE, 7'd127, 4'd0, 2'd0, 3'd0);
        send_item(dbba_pkg::ACT_ALLOCATE, 7'd65, 4'd0, 2'd0, 3'd0);
        send_item(dbba_pkg::ACT_ALLOCATE, 7'd1, 4'd0, 2'd0, 3'd0);
        send_item(dbba_pkg::ACT_ALLOCATE, 7'd64, 4'd0, 2'd0, 3'd0);
        // Fill the rest of the disk, then ask for one more block.
        send_item(dbba_pkg::ACT_ALLOCATE, 7'd63, 4'd0, 2'd0, 3'd0);
        send_item(dbba_pkg::ACT_ALLOCATE, 7'd1, 4'd0, 2'd0, 3'd0);
        send_item(dbba_pkg::ACT_RELEASE, 7'd0, 4'd0, 2'd0, 3'd0);
        send_item(dbba_pkg::ACT_RELEASE, 7'd0, 4'd0, 2'd0, 3'd0);
        send_item(dbba_pkg::ACT_RELEASE, 7'd127, 4'd7, 2'd1, 3'd3);
        send_item(dbba_pkg::ACT_RELEASE, 7'd0, 4'd15, 2'd1, 3'd3);
        send_item(dbba_pkg::ACT_RELEASE, 7'd0, 4'd8, 2'd0, 3'd0);
        send_item(dbba_pkg::ACT_RELEASE, 7'd0, 4'd0, 2'd3, 3'd0);
        send_item(dbba_pkg::ACT_RELEASE, 7'd0, 4'd0, 2'd2, 3'd7);
        send_item(dbba_pkg::ACT_RELEASE, 7'd0, 4'd0, 2'd0, 3'd4);
        send_item(dbba_pkg::ACT_RELEASE, 7'd0, 4'd3, 2'd0, 3'd2);
        send_item(dbba_pkg::ACT_ALLOCATE, 7'd3, 4'd0, 2'd0, 3'd0);
        send_item(dbba_pkg::ACT_RELEASE, 7'd0, 4'd7, 2'd1, 3'd3);
        send_item(dbba_pkg::ACT_RELEASE, 7'd0, 4'd7, 2'd1, 3'd3);
        send_item(dbba_pkg::ACT_ALLOCATE, 7'd64, 4'd0, 2'd0, 3'd0);
        send_item(dbba_pkg::ACT_ALLOCATE, 7'd2, 4'd0, 2'd0, 3'd0);

        in_valid <= 1'b0;
        while (pending_results != 0) @(negedge clk);

        for (int p = 0; p < 4; p++) begin
            sender_idle_pct    = phase_idle[p];
            receiver_stall_pct = phase_stall[p];
            repeat (ITEMS_PER_PHASE) send_random_item();
            if (p == 0) begin
                // Hold the result side off while items keep coming, so the block backs up.
                stall_requests++;
                send_item(dbba_pkg::ACT_ALLOCATE, 7'd4, 4'd0, 2'd0, 3'd0);
                repeat (5) send_random_item();
            end
        end

        in_valid <= 1'b0;
        while (pending_results != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Covered %0d items and %0d results: first-fit allocation up to a full disk,",
                 items_checked, results_checked);
        $display("empty and oversized requests, releases of taken, free and bad blocks, stalls.");
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
